FILE: hdl/tlse_pkg.sv
// Package for the text line store editor: sizes, command and state codes,
// and the queued command type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tlse_pkg;
   localparam int LINES  = 64;
   localparam int COLS   = 128;
   localparam int LINE_W = 6;
   localparam int COL_W  = 7;
   localparam int ADDR_W = LINE_W + COL_W;
   localparam int LEN_W  = 7;
   localparam int CNT_W  = 7;
   localparam int BYTE_W = 8;
   localparam int FUNC_W = 3;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INS_CHAR = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_INS_LINE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DEL_CHAR = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ     = 3'd4;

   localparam logic [LEN_W-1:0]  LEN_FULL  = LEN_W'(COLS - 1);
   localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(LINES - 1);
   localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(LINES);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLS);
   localparam logic [ADDR_W-1:0] BACK_STEP = '1;
   localparam logic [ADDR_W-1:0] FWD_STEP  = ADDR_W'(1);

   typedef enum logic [2:0] {
      OP_CLEAR, OP_INS_CHAR, OP_INS_LINE, OP_DEL_CHAR, OP_READ, OP_BAD
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [LINE_W-1:0]   line;
      logic [COL_W-1:0]    col;
      logic [BYTE_W-1:0]   ch;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LEN, ST_READ, ST_COPY, ST_FIN_CHAR, ST_FIN_LEN,
      ST_LN_REQ, ST_LN_LEN, ST_LN_WR, ST_LN_DONE, ST_RESULT
   } state_type;
endpackage
`default_nettype wire

FILE: hdl/tlse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tlse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

FILE: hdl/tlse_front.sv
// Front end: accepts request transactions, decodes the function code and
// holds them in a two-entry queue for the back end. Uses tlse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlse_front
   import tlse_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [LINE_W-1:0] req_line_index,
   input  wire logic [COL_W-1:0]  req_column,
   input  wire logic [BYTE_W-1:0] req_char_value,
   output logic                   q_valid,
   output cmd_type                q_item,
   input  wire logic              q_pop
);
   cmd_type    slot_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   cmd_type    dec;

   always_comb begin
      dec.line = req_line_index;
      dec.col  = req_column;
      dec.ch   = req_char_value;
      unique case (req_func)
         FUNC_CLEAR:    dec.op = OP_CLEAR;
         FUNC_INS_CHAR: dec.op = OP_INS_CHAR;
         FUNC_INS_LINE: dec.op = OP_INS_LINE;
         FUNC_DEL_CHAR: dec.op = OP_DEL_CHAR;
         FUNC_READ:     dec.op = OP_READ;
         default:       dec.op = OP_BAD;
      endcase
   end

   assign req_stall = fill_ff[1];
   assign push      = req_valid && !req_stall;
   assign q_valid   = fill_ff != 2'd0;
   assign q_item    = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? !wptr_ff : wptr_ff;
      rptr_in = q_pop ? !rptr_ff : rptr_ff;
      fill_in = fill_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= dec;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/tlse_back.sv
// Back end: sequencer that runs one queued command against the text RAM and
// the length RAM, and holds the response register. Uses tlse_pkg, tlse_ram.
`timescale 1ns / 1ps
`default_nettype none
module tlse_back
   import tlse_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire cmd_type           q_item,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_status,
   output logic [BYTE_W-1:0]      rsp_read_byte,
   output logic [LEN_W-1:0]       rsp_line_length,
   output logic [CNT_W-1:0]       rsp_lines_in_use
);
   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [COL_W-1:0]  n_ff, n_in;
   logic [COL_W-1:0]  wcol_ff, wcol_in;
   logic [ADDR_W-1:0] src_ff, src_in, dlt_ff, dlt_in, pend_addr_ff, pend_addr_in;
   logic              dn_ff, dn_in, pend_ff, pend_in;
   logic [LINE_W-1:0] i_ff, i_in, i_prev;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              status_ff, status_in;
   logic [BYTE_W-1:0] rbyte_ff, rbyte_in;
   logic [LINES-1:0]  vld_ff, vld_in;
   logic              rsp_valid_ff;
   logic              rsp_status_ff;
   logic [BYTE_W-1:0] rsp_rbyte_ff;
   logic [LEN_W-1:0]  rsp_len_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;

   logic              t_we;
   logic [ADDR_W-1:0] t_waddr, t_raddr;
   logic [BYTE_W-1:0] t_wdata, t_rdata;
   logic              l_we;
   logic [LINE_W-1:0] l_waddr, l_raddr;
   logic [LEN_W-1:0]  l_rdata;

   logic [LEN_W-1:0]  lenv, lnv;
   logic              copy_done, out_free;

   tlse_ram #(.WIDTH(BYTE_W), .DEPTH(LINES * COLS)) u_text (
      .clock(clock), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
      .raddr(t_raddr), .rdata(t_rdata)
   );

   tlse_ram #(.WIDTH(LEN_W), .DEPTH(LINES)) u_len (
      .clock(clock), .we(l_we), .waddr(l_waddr), .wdata(len_ff),
      .raddr(l_raddr), .rdata(l_rdata)
   );

   assign i_prev    = i_ff - LINE_W'(1);
   assign lenv      = vld_ff[cmd_ff.line] ? l_rdata : '0;
   assign lnv       = vld_ff[i_prev] ? l_rdata : '0;
   assign copy_done = (n_ff == '0) && !pend_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (q_valid) state_in = ST_LEN;
         ST_LEN: begin
            state_in = ST_RESULT;
            unique case (cmd_ff.op)
               OP_READ: if (cmd_ff.col < lenv) state_in = ST_READ;
               OP_INS_CHAR: begin
                  if (cmd_ff.col != LEN_FULL && lenv != LEN_FULL) begin
                     if (cmd_ff.ch == '0)         state_in = ST_FIN_LEN;
                     else if (cmd_ff.col <= lenv) state_in = ST_COPY;
                     else                         state_in = ST_FIN_CHAR;
                  end
               end
               OP_DEL_CHAR: if (cmd_ff.col < lenv) state_in = ST_COPY;
               OP_INS_LINE: begin
                  if (cmd_ff.line != LINE_LAST && count_ff != CNT_MAX) begin
                     state_in = (count_ff[LINE_W-1:0] > cmd_ff.line) ? ST_LN_REQ
                                                                     : ST_LN_DONE;
                  end
               end
               default: state_in = ST_RESULT;
            endcase
         end
         ST_READ:     state_in = ST_RESULT;
         ST_COPY: begin
            if (copy_done) begin
               unique case (cmd_ff.op)
                  OP_INS_CHAR: state_in = ST_FIN_CHAR;
                  OP_INS_LINE: state_in = ST_LN_WR;
                  default:     state_in = ST_FIN_LEN;
               endcase
            end
         end
         ST_FIN_CHAR: state_in = ST_FIN_LEN;
         ST_FIN_LEN:  state_in = ST_RESULT;
         ST_LN_REQ:   state_in = ST_LN_LEN;
         ST_LN_LEN:   state_in = ST_COPY;
         ST_LN_WR:    state_in = (i_prev > cmd_ff.line) ? ST_LN_REQ : ST_LN_DONE;
         ST_LN_DONE:  state_in = ST_RESULT;
         ST_RESULT:   if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // memory and queue strobes
   always_comb begin
      q_pop   = 1'b0;
      t_we    = 1'b0;
      t_waddr = pend_addr_ff;
      t_wdata = t_rdata;
      t_raddr = src_ff;
      l_we    = 1'b0;
      l_waddr = cmd_ff.line;
      l_raddr = q_item.line;
      unique case (state_ff)
         ST_IDLE:     q_pop = q_valid;
         ST_LEN:      t_raddr = {cmd_ff.line, cmd_ff.col};
         ST_COPY:     t_we = pend_ff;
         ST_FIN_CHAR: begin
            t_we    = 1'b1;
            t_waddr = {cmd_ff.line, wcol_ff};
            t_wdata = cmd_ff.ch;
         end
         ST_FIN_LEN:  l_we = 1'b1;
         ST_LN_REQ:   l_raddr = i_prev;
         ST_LN_WR: begin
            l_we    = 1'b1;
            l_waddr = i_ff;
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      cmd_in       = cmd_ff;
      len_in       = len_ff;
      n_in         = n_ff;
      wcol_in      = wcol_ff;
      src_in       = src_ff;
      dlt_in       = dlt_ff;
      dn_in        = dn_ff;
      pend_in      = 1'b0;
      pend_addr_in = src_ff + dlt_ff;
      i_in         = i_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      rbyte_in     = rbyte_ff;
      vld_in       = vld_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd_in    = q_item;
            status_in = 1'b1;
            rbyte_in  = '0;
         end
         ST_LEN: begin
            len_in = lenv;
            unique case (cmd_ff.op)
               OP_CLEAR: begin
                  vld_in    = '0;
                  count_in  = CNT_W'(1);
                  len_in    = '0;
                  status_in = 1'b0;
               end
               OP_INS_CHAR: begin
                  if (cmd_ff.col != LEN_FULL && lenv != LEN_FULL) begin
                     status_in = 1'b0;
                     wcol_in   = cmd_ff.col;
                     if (cmd_ff.ch == '0) begin
                        len_in = (cmd_ff.col < lenv) ? cmd_ff.col : lenv;
                     end else begin
                        len_in = lenv + LEN_W'(1);
                        n_in   = lenv - cmd_ff.col;
                        src_in = {cmd_ff.line, lenv - LEN_W'(1)};
                        dlt_in = FWD_STEP;
                        dn_in  = 1'b1;
                        if (cmd_ff.col > lenv) wcol_in = lenv;
                     end
                  end
               end
               OP_DEL_CHAR: begin
                  if (cmd_ff.col < lenv) begin
                     status_in = 1'b0;
                     len_in    = lenv - LEN_W'(1);
                     n_in      = lenv - cmd_ff.col - COL_W'(1);
                     src_in    = {cmd_ff.line, cmd_ff.col + COL_W'(1)};
                     dlt_in    = BACK_STEP;
                     dn_in     = 1'b0;
                  end
               end
               OP_INS_LINE: i_in = count_ff[LINE_W-1:0];
               default: ;
            endcase
         end
         ST_READ: begin
            rbyte_in  = t_rdata;
            status_in = 1'b0;
         end
         ST_COPY: begin
            if (n_ff != '0) begin
               pend_in = 1'b1;
               n_in    = n_ff - COL_W'(1);
               src_in  = dn_ff ? src_ff - FWD_STEP : src_ff + FWD_STEP;
            end
         end
         ST_FIN_LEN: vld_in[cmd_ff.line] = 1'b1;
         ST_LN_LEN: begin
            len_in = lnv;
            n_in   = lnv;
            src_in = {i_prev, COL_W'(0)};
            dlt_in = ROW_STEP;
            dn_in  = 1'b0;
         end
         ST_LN_WR: begin
            vld_in[i_ff] = 1'b1;
            i_in         = i_prev;
         end
         ST_LN_DONE: begin
            vld_in[cmd_ff.line] = 1'b0;
            count_in  = count_ff + CNT_W'(1);
            len_in    = '0;
            status_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= CNT_W'(1);
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         count_ff <= count_in;
         vld_ff   <= vld_in;
         if (state_ff == ST_RESULT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      cmd_ff       <= cmd_in;
      len_ff       <= len_in;
      n_ff         <= n_in;
      wcol_ff      <= wcol_in;
      src_ff       <= src_in;
      dlt_ff       <= dlt_in;
      dn_ff        <= dn_in;
      pend_addr_ff <= pend_addr_in;
      i_ff         <= i_in;
      status_ff    <= status_in;
      rbyte_ff     <= rbyte_in;
      if (state_ff == ST_RESULT && out_free) begin
         rsp_status_ff <= status_ff;
         rsp_rbyte_ff  <= rbyte_ff;
         rsp_len_ff    <= len_ff;
         rsp_cnt_ff    <= count_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_read_byte    = rsp_rbyte_ff;
   assign rsp_line_length  = rsp_len_ff;
   assign rsp_lines_in_use = rsp_cnt_ff;
endmodule
`default_nettype wire

FILE: hdl/text_line_store_editor.sv
// Top level of the text line store editor: front queue plus back sequencer.
// Uses tlse_pkg, tlse_front, tlse_back.
`timescale 1ns / 1ps
//
// Holds 64 lines of up to 127 bytes each in a block RAM, with line lengths in
// a small RAM and one valid bit per line (reset and clear need no sweep).
// Each request transaction gives exactly one response transaction. Cost per
// transaction is set by the back-end sequencer, which moves one byte per cycle
// through the single text RAM port pair: insert char and delete char shift
// the line's tail bytes (up to 126), while insert line moves the given line
// and every later line in use down one row, copying each line's bytes. A
// two-entry queue takes requests while a command runs or a response waits.
`default_nettype none
module text_line_store_editor
   import tlse_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [LINE_W-1:0] req_line_index,
   input  wire logic [COL_W-1:0]  req_column,
   input  wire logic [BYTE_W-1:0] req_char_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_status,
   output logic [BYTE_W-1:0]      rsp_read_byte,
   output logic [LEN_W-1:0]       rsp_line_length,
   output logic [CNT_W-1:0]       rsp_lines_in_use
);
   logic    q_valid, q_pop;
   cmd_type q_item;

   tlse_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_line_index(req_line_index), .req_column(req_column),
      .req_char_value(req_char_value),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   tlse_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_read_byte(rsp_read_byte), .rsp_line_length(rsp_line_length),
      .rsp_lines_in_use(rsp_lines_in_use)
   );
endmodule
`default_nettype wire
